// ===== src/lr_pkg.sv =====
package lr_pkg;

    localparam int CFG_W      = 12;
    localparam int CFG_ADDR_W = 1;
    localparam int COLOR_W    = 24;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd1024;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd768;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } reg_idx_t;

    typedef enum logic {
        FUNC_START = 1'b0,
        FUNC_STEP  = 1'b1
    } func_t;

endpackage

// ===== src/lr_setup.sv =====
// Line setup: pick the major axis, order the endpoints, derive deltas and
// the initial error term.
module lr_setup #(
    parameter int COORD_BITS = 12
) (
    input  logic signed [COORD_BITS-1:0] x_start,
    input  logic signed [COORD_BITS-1:0] y_start,
    input  logic signed [COORD_BITS-1:0] x_end,
    input  logic signed [COORD_BITS-1:0] y_end,
    output logic                         steep,
    output logic                         minor_dir,
    output logic signed [COORD_BITS-1:0] start_major,
    output logic signed [COORD_BITS-1:0] start_minor,
    output logic signed [COORD_BITS-1:0] end_major,
    output logic        [COORD_BITS:0]   delta_major,
    output logic        [COORD_BITS:0]   delta_minor,
    output logic signed [COORD_BITS+2:0] error_init
);

    localparam int C = COORD_BITS;

    logic signed [C:0]   dx;
    logic signed [C:0]   dy;
    logic        [C:0]   adx;
    logic        [C:0]   ady;
    logic signed [C-1:0] ma;
    logic signed [C-1:0] na;
    logic signed [C-1:0] mb;
    logic signed [C-1:0] nb;
    logic                swap;
    logic signed [C:0]   dn;
    logic signed [C:0]   dm;

    always_comb
    begin
        dx  = {x_end[C-1], x_end} - {x_start[C-1], x_start};
        dy  = {y_end[C-1], y_end} - {y_start[C-1], y_start};
        adx = dx[C] ? (C+1)'(-dx) : dx;
        ady = dy[C] ? (C+1)'(-dy) : dy;
        steep = !(ady < adx);

        if (steep)
        begin
            ma = y_start;
            na = x_start;
            mb = y_end;
            nb = x_end;
        end
        else
        begin
            ma = x_start;
            na = y_start;
            mb = x_end;
            nb = y_end;
        end

        // walk the major axis upward
        swap        = ma > mb;
        start_major = swap ? mb : ma;
        end_major   = swap ? ma : mb;
        start_minor = swap ? nb : na;

        dn = swap ? ({na[C-1], na} - {nb[C-1], nb}) : ({nb[C-1], nb} - {na[C-1], na});
        dm = {end_major[C-1], end_major} - {start_major[C-1], start_major};

        minor_dir   = dn[C];
        delta_minor = dn[C] ? (C+1)'(-dn) : dn;
        delta_major = dm;
        error_init  = $signed({1'b0, delta_minor, 1'b0}) - $signed({2'b00, delta_major});
    end

endmodule

// ===== src/lr_stepper.sv =====
// Line state and output register. One step item per cycle, while the output is
// not stalled, emits the current pixel and, short of the end point, advances the error term.
module lr_stepper #(
    parameter int COORD_BITS = 12
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  lr_pkg::func_t                in_func,
    input  logic [lr_pkg::COLOR_W-1:0]   in_color,
    input  logic                         set_steep,
    input  logic                         set_minor_dir,
    input  logic signed [COORD_BITS-1:0] set_start_major,
    input  logic signed [COORD_BITS-1:0] set_start_minor,
    input  logic signed [COORD_BITS-1:0] set_end_major,
    input  logic        [COORD_BITS:0]   set_delta_major,
    input  logic        [COORD_BITS:0]   set_delta_minor,
    input  logic signed [COORD_BITS+2:0] set_error_init,
    input  logic [lr_pkg::CFG_W-1:0]     image_width,
    input  logic [lr_pkg::CFG_W-1:0]     image_height,
    output logic                         take,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic signed [COORD_BITS-1:0] pixel_x,
    output logic signed [COORD_BITS-1:0] pixel_y,
    output logic [lr_pkg::COLOR_W-1:0]   pixel_color,
    output logic                         inside_res,
    output logic                         last
);

    localparam int C    = COORD_BITS;
    localparam int EW   = C + 3;
    localparam int CMPW = (C > lr_pkg::CFG_W) ? C : lr_pkg::CFG_W;

    logic                          active_reg, active_next;
    logic                          steep_reg;
    logic                          minor_dir_reg;
    logic signed [C-1:0]           cur_major_reg;
    logic signed [C-1:0]           cur_minor_reg;
    logic signed [C-1:0]           end_major_reg;
    logic        [C:0]             delta_major_reg;
    logic        [C:0]             delta_minor_reg;
    logic signed [EW-1:0]          error_reg;
    logic [lr_pkg::COLOR_W-1:0]    color_reg;
    logic                          out_valid_reg, out_valid_next;
    logic signed [C-1:0]           px_reg;
    logic signed [C-1:0]           py_reg;
    logic [lr_pkg::COLOR_W-1:0]    pcolor_reg;
    logic                          inside_reg;
    logic                          last_reg;

    logic                          do_start;
    logic                          do_step;
    logic signed [C-1:0]           px;
    logic signed [C-1:0]           py;
    logic                          fin;
    logic                          in_image;
    logic signed [EW-1:0]          err_up;
    logic signed [EW-1:0]          err_flat;

    always_comb
    begin
        take     = !out_valid_reg || out_ready;
        do_start = in_valid && take && (in_func == lr_pkg::FUNC_START);
        do_step  = in_valid && take && (in_func == lr_pkg::FUNC_STEP) && active_reg;

        px  = steep_reg ? cur_minor_reg : cur_major_reg;
        py  = steep_reg ? cur_major_reg : cur_minor_reg;
        fin = cur_major_reg >= end_major_reg;
        in_image = !px[C-1] && !py[C-1]
                && (CMPW'(px[C-2:0]) < CMPW'(image_width))
                && (CMPW'(py[C-2:0]) < CMPW'(image_height));

        err_up   = $signed({1'b0, delta_minor_reg, 1'b0}) - $signed({1'b0, delta_major_reg, 1'b0});
        err_flat = $signed({1'b0, delta_minor_reg, 1'b0});

        active_next = active_reg;
        if (do_start)
            active_next = 1'b1;
        else if (do_step && fin)
            active_next = 1'b0;

        out_valid_next = take ? do_step : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg      <= 1'b0;
            steep_reg       <= 1'b0;
            minor_dir_reg   <= 1'b0;
            cur_major_reg   <= '0;
            cur_minor_reg   <= '0;
            end_major_reg   <= '0;
            delta_major_reg <= '0;
            delta_minor_reg <= '0;
            error_reg       <= '0;
            color_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
            if (do_start)
            begin
                steep_reg       <= set_steep;
                minor_dir_reg   <= set_minor_dir;
                cur_major_reg   <= set_start_major;
                cur_minor_reg   <= set_start_minor;
                end_major_reg   <= set_end_major;
                delta_major_reg <= set_delta_major;
                delta_minor_reg <= set_delta_minor;
                error_reg       <= set_error_init;
                color_reg       <= in_color;
            end
            else if (do_step && !fin)
            begin
                cur_major_reg <= cur_major_reg + C'(1);
                if (error_reg > 0)
                begin
                    cur_minor_reg <= minor_dir_reg ? (cur_minor_reg - C'(1))
                                                   : (cur_minor_reg + C'(1));
                    error_reg     <= error_reg + err_up;
                end
                else
                begin
                    error_reg <= error_reg + err_flat;
                end
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (do_step)
        begin
            px_reg     <= px;
            py_reg     <= py;
            pcolor_reg <= color_reg;
            inside_reg <= in_image;
            last_reg   <= fin;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_x     = px_reg;
    assign pixel_y     = py_reg;
    assign pixel_color = pcolor_reg;
    assign inside_res  = inside_reg;
    assign last        = last_reg;

endmodule

// ===== src/line_rasterizer.sv =====
// Bresenham line generator.
// Input stream s_*: tuser = func (0 start a line, 1 step one pixel),
// tdata = x_start, y_start, x_end, y_end, line_color. A start item loads the
// endpoints and color and emits nothing; each step item emits one pixel on
// m_*: tdata = pixel_x, pixel_y, pixel_color, tuser = inside flag, tlast on
// the final endpoint. Steps while no line is active emit nothing, and a start
// while drawing drops the current line.
// An accepted step item passes the input register, then the line state and
// output register, before its pixel shows on m_*. Throughput: one item per
// cycle while m_tready is high; the per-pixel error update is a single add and compare.
// cfg_we/cfg_addr/cfg_wdata write image_width (0) and image_height (1); write
// only while no item is in flight.
// Reset: no line active, image size 1024 x 768, both registers emptied.
// When m_tready is low the result holds; one further item waits in the input
// register and s_tready drops after that.
module line_rasterizer #(
    parameter int COORD_BITS = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [lr_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [lr_pkg::CFG_W-1:0]          cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // x_start, y_start, x_end, y_end, line_color (low bits first), zero padded
    input  logic [((4*COORD_BITS+lr_pkg::COLOR_W+7)/8)*8-1:0] s_tdata,
    // func
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // pixel_x, pixel_y, pixel_color (low bits first), zero padded
    output logic [((2*COORD_BITS+lr_pkg::COLOR_W+7)/8)*8-1:0] m_tdata,
    // inside_res
    output logic                              m_tuser,
    output logic                              m_tlast
);

    localparam int C     = COORD_BITS;
    localparam int OUT_W = ((2*C+lr_pkg::COLOR_W+7)/8)*8;

    logic                        in_valid_reg;
    lr_pkg::func_t               func_reg;
    logic signed [C-1:0]         xs_reg;
    logic signed [C-1:0]         ys_reg;
    logic signed [C-1:0]         xe_reg;
    logic signed [C-1:0]         ye_reg;
    logic [lr_pkg::COLOR_W-1:0]  color_reg;
    logic [lr_pkg::CFG_W-1:0]    width_reg;
    logic [lr_pkg::CFG_W-1:0]    height_reg;

    logic                        take;
    logic                        accept;
    logic                        set_steep;
    logic                        set_minor_dir;
    logic signed [C-1:0]         set_start_major;
    logic signed [C-1:0]         set_start_minor;
    logic signed [C-1:0]         set_end_major;
    logic        [C:0]           set_delta_major;
    logic        [C:0]           set_delta_minor;
    logic signed [C+2:0]         set_error_init;
    logic signed [C-1:0]         pixel_x;
    logic signed [C-1:0]         pixel_y;
    logic [lr_pkg::COLOR_W-1:0]  pixel_color;

    assign s_tready = !in_valid_reg || take;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            width_reg    <= lr_pkg::WIDTH_RESET;
            height_reg   <= lr_pkg::HEIGHT_RESET;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (cfg_we)
            begin
                unique case (lr_pkg::reg_idx_t'(cfg_addr))
                    lr_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_wdata;
                    lr_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_wdata;
                    default:                  width_reg  <= width_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg  <= lr_pkg::func_t'(s_tuser);
            xs_reg    <= s_tdata[C-1:0];
            ys_reg    <= s_tdata[2*C-1:C];
            xe_reg    <= s_tdata[3*C-1:2*C];
            ye_reg    <= s_tdata[4*C-1:3*C];
            color_reg <= s_tdata[4*C+lr_pkg::COLOR_W-1:4*C];
        end
    end

    lr_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .x_start     (xs_reg),
        .y_start     (ys_reg),
        .x_end       (xe_reg),
        .y_end       (ye_reg),
        .steep       (set_steep),
        .minor_dir   (set_minor_dir),
        .start_major (set_start_major),
        .start_minor (set_start_minor),
        .end_major   (set_end_major),
        .delta_major (set_delta_major),
        .delta_minor (set_delta_minor),
        .error_init  (set_error_init)
    );

    lr_stepper #(
        .COORD_BITS (COORD_BITS)
    ) u_stepper (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid_reg),
        .in_func         (func_reg),
        .in_color        (color_reg),
        .set_steep       (set_steep),
        .set_minor_dir   (set_minor_dir),
        .set_start_major (set_start_major),
        .set_start_minor (set_start_minor),
        .set_end_major   (set_end_major),
        .set_delta_major (set_delta_major),
        .set_delta_minor (set_delta_minor),
        .set_error_init  (set_error_init),
        .image_width     (width_reg),
        .image_height    (height_reg),
        .take            (take),
        .out_ready       (m_tready),
        .out_valid       (m_tvalid),
        .pixel_x         (pixel_x),
        .pixel_y         (pixel_y),
        .pixel_color     (pixel_color),
        .inside_res      (m_tuser),
        .last            (m_tlast)
    );

    assign m_tdata = OUT_W'({pixel_color, pixel_y, pixel_x});

endmodule

// ===== src/lr_checker.sv =====
module lr_checker #(
    parameter int COORD_BITS = 12
) (
    input logic                                                   clk,
    input logic                                                   rst_n,
    input logic                                                   s_tvalid,
    input logic                                                   s_tready,
    input logic                                                   s_tuser,
    input logic                                                   m_tvalid,
    input logic                                                   m_tready,
    input logic [((2*COORD_BITS+lr_pkg::COLOR_W+7)/8)*8-1:0]      m_tdata,
    input logic                                                   m_tuser,
    input logic                                                   m_tlast
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

    // a fresh pixel traces back to an accepted step item through the input register and the output register
    a_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && (s_tuser == lr_pkg::FUNC_STEP), 2))
        else $error("pixel without a step item");

    // empty output side never blocks the input
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with output empty");

endmodule

bind line_rasterizer lr_checker #(
    .COORD_BITS (COORD_BITS)
) u_lr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    localparam int CB    = 12;
    localparam int IN_W  = ((4*CB+lr_pkg::COLOR_W+7)/8)*8;
    localparam int OUT_W = ((2*CB+lr_pkg::COLOR_W+7)/8)*8;

    typedef struct packed {
        lr_pkg::func_t              func;
        logic [CB-1:0]              xs;
        logic [CB-1:0]              ys;
        logic [CB-1:0]              xe;
        logic [CB-1:0]              ye;
        logic [lr_pkg::COLOR_W-1:0] color;
    } line_item_t;

    typedef struct packed {
        logic [CB-1:0]              px;
        logic [CB-1:0]              py;
        logic [lr_pkg::COLOR_W-1:0] color;
        logic                       in_img;
        logic                       last;
    } pixel_t;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          cfg_we    = 1'b0;
    logic [lr_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [lr_pkg::CFG_W-1:0]      cfg_wdata = '0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [IN_W-1:0]               s_tdata   = '0;
    logic                          s_tuser   = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [OUT_W-1:0]              m_tdata;
    logic                          m_tuser;
    logic                          m_tlast;

    // pen state mirrored from the block
    logic [lr_pkg::CFG_W-1:0]      img_w     = lr_pkg::WIDTH_RESET;
    logic [lr_pkg::CFG_W-1:0]      img_h     = lr_pkg::HEIGHT_RESET;
    logic                          drawing   = 1'b0;
    logic                          y_major   = 1'b0;
    logic                          min_neg   = 1'b0;
    logic signed [CB-1:0]          pos_maj   = '0;
    logic signed [CB-1:0]          pos_min   = '0;
    logic signed [CB-1:0]          stop_maj  = '0;
    logic [CB:0]                   run_maj   = '0;
    logic [CB:0]                   run_min   = '0;
    logic signed [15:0]            err_acc   = '0;
    logic [lr_pkg::COLOR_W-1:0]    pen_color = '0;

    line_item_t queued_items[$];
    line_item_t on_bus;
    pixel_t     pixels_due[$];
    pixel_t     want;
    int         items_pushed   = 0;
    int         items_accepted = 0;
    int         pixels_seen    = 0;
    int         hold_left      = 0;
    int         errors         = 0;
    logic       steady         = 1'b0;

    line_rasterizer #(
        .COORD_BITS(CB)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Advance the pen by one accepted item and queue the pixel it emits, if any.
    function automatic void advance_pen(input line_item_t it);
        int     ax, ay, bx, by, adx, ady, ma, na, mb, nb, tmp, dn, px, py;
        pixel_t pix;
        if (it.func == lr_pkg::FUNC_START)
        begin
            ax  = $signed(it.xs);
            ay  = $signed(it.ys);
            bx  = $signed(it.xe);
            by  = $signed(it.ye);
            adx = bx - ax;
            ady = by - ay;
            if (adx < 0)
                adx = -adx;
            if (ady < 0)
                ady = -ady;
            y_major = !(ady < adx);
            if (y_major)
            begin
                ma = ay; na = ax; mb = by; nb = bx;
            end
            else
            begin
                ma = ax; na = ay; mb = bx; nb = by;
            end
            if (ma > mb)
            begin
                tmp = ma; ma = mb; mb = tmp;
                tmp = na; na = nb; nb = tmp;
            end
            dn        = nb - na;
            min_neg   = dn < 0;
            if (dn < 0)
                dn = -dn;
            run_min   = (CB+1)'(dn);
            run_maj   = (CB+1)'(mb - ma);
            pos_maj   = CB'(ma);
            pos_min   = CB'(na);
            stop_maj  = CB'(mb);
            err_acc   = 16'(2 * dn - (mb - ma));
            pen_color = it.color;
            drawing   = 1'b1;
        end
        else if (drawing)
        begin
            px = y_major ? pos_min : pos_maj;
            py = y_major ? pos_maj : pos_min;
            pix.px     = px[CB-1:0];
            pix.py     = py[CB-1:0];
            pix.color  = pen_color;
            pix.in_img = px >= 0 && py >= 0 && px < int'(img_w) && py < int'(img_h);
            pix.last   = pos_maj >= stop_maj;
            if (pix.last)
                drawing = 1'b0;
            else
            begin
                pos_maj = CB'(pos_maj + 1);
                if (err_acc > 0)
                begin
                    pos_min = min_neg ? CB'(pos_min - 1) : CB'(pos_min + 1);
                    err_acc = 16'(err_acc + 2 * (int'(run_min) - int'(run_maj)));
                end
                else
                    err_acc = 16'(err_acc + 2 * int'(run_min));
            end
            pixels_due = {pixels_due, pix};
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] got_v);
        if (exp_v !== got_v)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
            errors++;
        end
    endfunction

    // Sender: present queued items, idling at random.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                advance_pen(on_bus);
                items_accepted++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (queued_items.size() > 0 && (steady || $urandom_range(99) >= 16))
                begin
                    on_bus = queued_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {on_bus.color, on_bus.ye, on_bus.xe, on_bus.ys, on_bus.xs};
                    s_tuser  <= on_bus.func;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: check each pixel against the oldest expected one.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                pixels_seen++;
                if (pixels_due.size() == 0)
                begin
                    $error("unexpected pixel: tdata 0x%0h, inside %0b, last %0b",
                           m_tdata, m_tuser, m_tlast);
                    errors++;
                end
                else
                begin
                    want = pixels_due.pop_front();
                    check_field("pixel_x", 32'(want.px), 32'(m_tdata[CB-1:0]));
                    check_field("pixel_y", 32'(want.py), 32'(m_tdata[2*CB-1:CB]));
                    check_field("pixel_color", 32'(want.color),
                                32'(m_tdata[2*CB+lr_pkg::COLOR_W-1:2*CB]));
                    check_field("inside_res", 32'(want.in_img), 32'(m_tuser));
                    check_field("last", 32'(want.last), 32'(m_tlast));
                end
                // hold off long enough to back the block up into its input
                if (pixels_seen == 100)
                    hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= steady || $urandom_range(99) >= 16;
        end
    end

    function automatic int clamp_coord(input int v);
        return v < -2048 ? -2048 : (v > 2047 ? 2047 : v);
    endfunction

    // Mix of anywhere, around the origin, and around the image border.
    function automatic int pick_coord(input int lim);
        case ($urandom_range(2))
            0:       return int'($urandom_range(4095)) - 2048;
            1:       return int'($urandom_range(56)) - 16;
            default: return clamp_coord(lim + int'($urandom_range(32)) - 16);
        endcase
    endfunction

    function automatic line_item_t noise_item(input lr_pkg::func_t f);
        line_item_t it;
        it.func  = f;
        it.xs    = CB'($urandom);
        it.ys    = CB'($urandom);
        it.xe    = CB'($urandom);
        it.ye    = CB'($urandom);
        it.color = lr_pkg::COLOR_W'($urandom);
        return it;
    endfunction

    task automatic push_item(input line_item_t it);
        queued_items = {queued_items, it};
        items_pushed++;
    endtask

    task automatic push_line(input int xs, input int ys, input int xe, input int ye,
                             input logic [lr_pkg::COLOR_W-1:0] color, input int steps);
        line_item_t it;
        it.func  = lr_pkg::FUNC_START;
        it.xs    = xs[CB-1:0];
        it.ys    = ys[CB-1:0];
        it.xe    = xe[CB-1:0];
        it.ye    = ye[CB-1:0];
        it.color = color;
        push_item(it);
        repeat (steps)
            push_item(noise_item(lr_pkg::FUNC_STEP));
    endtask

    task automatic push_random(input int count);
        int n, r, span, xs, ys, xe, ye, len;
        n = 0;
        while (n < count)
        begin
            r = $urandom_range(99);
            if (r < 70)
            begin
                span = ($urandom_range(9) == 0) ? 200 : 12;
                xs   = pick_coord(int'(img_w));
                ys   = pick_coord(int'(img_h));
                xe   = clamp_coord(xs + int'($urandom_range(2*span)) - span);
                ye   = clamp_coord(ys + int'($urandom_range(2*span)) - span);
                len  = (xe > xs ? xe - xs : xs - xe);
                if ((ye > ys ? ye - ys : ys - ye) > len)
                    len = (ye > ys ? ye - ys : ys - ye);
                len  = len + 1;
                // sometimes cut the line short, sometimes step past its end
                case ($urandom_range(7))
                    0:       len = $urandom_range(len);
                    1:       len = len + $urandom_range(3, 1);
                    default: ;
                endcase
                push_line(xs, ys, xe, ye, lr_pkg::COLOR_W'($urandom), len);
                n += len + 1;
            end
            else if (r < 85)
            begin
                len = $urandom_range(20, 1);
                push_line(int'($urandom_range(4095)) - 2048, int'($urandom_range(4095)) - 2048,
                          int'($urandom_range(4095)) - 2048, int'($urandom_range(4095)) - 2048,
                          lr_pkg::COLOR_W'($urandom), len);
                n += len + 1;
            end
            else
            begin
                len = $urandom_range(3, 1);
                repeat (len)
                    push_item(noise_item(lr_pkg::func_t'($urandom_range(1))));
                n += len;
            end
        end
    endtask

    // Wait until every item is taken and every pixel has come out.
    task automatic drain;
        int guard;
        guard = 0;
        while (items_accepted != items_pushed || pixels_due.size() > 0)
        begin
            @(posedge clk);
            guard++;
            if (guard > 50000)
                break;
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic set_image(input logic [lr_pkg::CFG_W-1:0] w,
                             input logic [lr_pkg::CFG_W-1:0] h);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= lr_pkg::REG_IMAGE_WIDTH;
        cfg_wdata <= w;
        @(posedge clk);
        cfg_addr  <= lr_pkg::REG_IMAGE_HEIGHT;
        cfg_wdata <= h;
        @(posedge clk);
        cfg_we    <= 1'b0;
        img_w = w;
        img_h = h;
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // step with no line loaded
        push_item(noise_item(lr_pkg::FUNC_STEP));
        // single point line, then a step past its end
        push_line(0, 0, 0, 0, 24'hFFFFFF, 2);
        // full-range diagonal, dropped by a start while drawing
        push_line(-2048, -2048, 2047, 2047, 24'h000000, 2);
        push_line(2047, -2048, -2048, 2047, 24'hA5A5A5, 1);
        // shallow line given right to left, minor axis going down
        push_line(3, 1, 0, 2, 24'h5A5A5A, 4);
        // steep line across the image corner
        push_line(1023, 767, 1024, 769, 24'h123456, 3);
        // horizontal line through x = 0
        push_line(-1, 5, 2, 5, 24'h800001, 4);
        // vertical line at the top edge, given downward
        push_line(0, 2047, 0, 2045, 24'h7FFFFE, 3);
        push_random(300);
        drain();

        set_image(12'd1, 12'd1);
        push_random(270);
        drain();

        set_image(12'd4095, 12'd4095);
        push_random(270);
        drain();

        // zero size: nothing is inside
        set_image(12'd0, 12'd0);
        push_random(270);
        drain();

        steady <= 1'b1;
        set_image(12'd2048, 12'd2048);
        push_random(270);
        drain();
        steady <= 1'b0;

        set_image(lr_pkg::CFG_W'($urandom_range(4095)), lr_pkg::CFG_W'($urandom_range(4095)));
        push_random(270);
        drain();

        if (pixels_due.size() != 0)
        begin
            $error("%0d expected pixels never emitted", pixels_due.size());
            errors++;
        end
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
